// ----- hdl/polynomial_trapezoid_average_defines.svh -----
`ifndef POLYNOMIAL_TRAPEZOID_AVERAGE_DEFINES_SVH
`define POLYNOMIAL_TRAPEZOID_AVERAGE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define PTAVG_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define PTAVG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/ptavg_pkg.sv -----
`default_nettype none

package ptavg_pkg;

	localparam int TIME_W   = 32;
	localparam int STEP_W   = 11;
	localparam int COEF_W   = 16;
	localparam int DEG_W    = 3;
	localparam int NUM_COEF = 6;
	localparam int ACC_W    = 48;
	localparam int SUM_W    = 64;
	localparam int DEN_W    = STEP_W + 1;
	localparam int DIV_W    = 64;
	localparam int DCNT_W   = $clog2(DIV_W);
	localparam int ADDR_W   = 3;
	localparam int DATA_W   = 16;
	localparam int STAT_W   = 2;
	localparam int WIDE_W   = 80;

	localparam logic [ACC_W-1:0] OUT_MAX = 48'h7FFF_FFFF_FFFF;
	localparam logic [ACC_W-1:0] OUT_MIN = 48'h8000_0000_0000;
	localparam logic signed [SUM_W-1:0] SUM_LIM = 64'sh4000_0000_0000_0000;
	localparam logic signed [SUM_W-1:0] SUM_MIN = 64'shC000_0000_0000_0000;

	// register map
	localparam logic [ADDR_W-1:0] REG_DEGREE     = 3'd0;
	localparam logic [ADDR_W-1:0] REG_COEF_FIRST = 3'd1;
	localparam logic [ADDR_W-1:0] REG_COEF_LAST  = 3'd6;

	typedef enum logic [STAT_W-1:0] {
		ST_OK         = 2'd0,
		ST_ZERO_LEN   = 2'd1,
		ST_ZERO_STEPS = 2'd2,
		ST_SAT        = 2'd3
	} status_t;

	typedef enum logic [9:0] {
		S_IDLE  = 10'b00_0000_0001,
		S_DIVH  = 10'b00_0000_0010,
		S_POINT = 10'b00_0000_0100,
		S_MLO   = 10'b00_0000_1000,
		S_MHI   = 10'b00_0001_0000,
		S_SCALE = 10'b00_0010_0000,
		S_ADDC  = 10'b00_0100_0000,
		S_SUM   = 10'b00_1000_0000,
		S_DIVM  = 10'b01_0000_0000,
		S_DONE  = 10'b10_0000_0000
	} state_t;

endpackage

`default_nettype wire

// ----- hdl/ptavg_if.sv -----
`default_nettype none

interface ptavg_job_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [ptavg_pkg::TIME_W-1:0]   t_start;
	logic signed [ptavg_pkg::TIME_W-1:0]   t_end;
	logic        [ptavg_pkg::STEP_W-1:0]   step_count;

	modport source (output valid, output t_start, output t_end, output step_count,
		input ready);
	modport sink (input valid, input t_start, input t_end, input step_count,
		output ready);
endinterface

interface ptavg_res_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [ptavg_pkg::ACC_W-1:0]    avg_velocity;
	logic        [ptavg_pkg::STAT_W-1:0]   status;

	modport source (output valid, output avg_velocity, output status, input ready);
	modport sink (input valid, input avg_velocity, input status, output ready);
endinterface

interface ptavg_cfg_if;
	logic                                  valid;
	logic                                  ready;
	logic [ptavg_pkg::ADDR_W-1:0]          addr;
	logic [ptavg_pkg::DATA_W-1:0]          data;

	modport source (output valid, output addr, output data, input ready);
	modport sink (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/polynomial_trapezoid_average.sv -----
// Trapezoid-rule mean of a configured polynomial (degree up to 5, Q16.16 time).
// cfg: register writes (addr 0 degree, 1..6 coef_0..coef_5), always ready;
//   write only while no job is in flight. Unknown addresses are dropped.
// job: one transaction per job carrying t_start, t_end and step_count.
//   job.ready is high only while the sequencer is idle.
// res: one transaction per job with avg_velocity (Q32.16) and status.
// A job divides for the step, evaluates the polynomial at n+1 points (n the
// clamped step count) by Horner's rule up to the clamped degree d, and
// divides for the mean. The single 32x32 multiplier gives two partial
// products per Horner step, then scale and coefficient add; the radix-2
// divider is shared by the step and the final mean. Error jobs go straight to done.
// The result sits in an output register, so the next job is taken while it
// waits; a stalled receiver only holds the finished job in its last state.
// Reset clears the configuration registers to zero, empties the output and idles the block.
`default_nettype none

module polynomial_trapezoid_average #(
	parameter int MAX_DEGREE = 5,
	parameter int MAX_STEPS  = 1024,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	ptavg_cfg_if.sink   cfg,
	ptavg_job_if.sink   job,
	ptavg_res_if.source res
);

	localparam int ACC_W  = ptavg_pkg::ACC_W;
	localparam int COEF_W = ptavg_pkg::COEF_W;
	localparam int STEP_W = ptavg_pkg::STEP_W;
	localparam int DEG_W  = ptavg_pkg::DEG_W;
	localparam int DEN_W  = ptavg_pkg::DEN_W;
	localparam int DIV_W  = ptavg_pkg::DIV_W;
	localparam int SUM_W  = ptavg_pkg::SUM_W;
	localparam int WIDE_W = ptavg_pkg::WIDE_W;
	localparam int DEG_LIM = (MAX_DEGREE < ptavg_pkg::NUM_COEF - 1) ?
		MAX_DEGREE : ptavg_pkg::NUM_COEF - 1;
	localparam int MAG_W  = 79 - FRAC_BITS;
	localparam int STEP_MAXV = (1 << STEP_W) - 1;
	localparam logic [STEP_W-1:0] N_MAX = (MAX_STEPS > STEP_MAXV) ?
		STEP_W'(STEP_MAXV) : STEP_W'(MAX_STEPS);

	function automatic logic [ACC_W:0] sat48(input logic [WIDE_W-1:0] mag, input logic neg);
		logic [ACC_W:0] r;
		if (neg) begin
			if (mag > WIDE_W'(ptavg_pkg::OUT_MIN))
				r = {1'b1, ptavg_pkg::OUT_MIN};
			else
				r = {1'b0, ~mag[ACC_W-1:0] + ACC_W'(1)};
		end else begin
			if (mag > WIDE_W'(ptavg_pkg::OUT_MAX))
				r = {1'b1, ptavg_pkg::OUT_MAX};
			else
				r = {1'b0, mag[ACC_W-1:0]};
		end
		return r;
	endfunction

	ptavg_pkg::state_t state_q;

	logic [DEG_W-1:0]            poly_deg_q;
	logic [COEF_W-1:0]           coef_q [ptavg_pkg::NUM_COEF];

	logic [DIV_W-1:0]            num_q;
	logic [DEN_W-1:0]            rem_q;
	logic [DEN_W-1:0]            den_q;
	logic [ptavg_pkg::DCNT_W-1:0] dcnt_q;
	logic                        dneg_q;

	logic [ptavg_pkg::TIME_W-1:0] x_q;
	logic [ptavg_pkg::TIME_W:0]  h_q;
	logic [STEP_W-1:0]           n_q;
	logic [STEP_W-1:0]           i_q;
	logic [DEG_W-1:0]            deg_q;
	logic [DEG_W-1:0]            k_q;
	logic [ACC_W-1:0]            acc_q;
	logic [63:0]                 plo_q;
	logic [ACC_W-1:0]            phi_q;
	logic signed [SUM_W-1:0]     sum_q;
	logic                        ov_q;

	logic [ACC_W-1:0]            fin_avg_q;
	logic [ptavg_pkg::STAT_W-1:0] fin_status_q;
	logic                        res_valid_q;
	logic [ACC_W-1:0]            res_avg_q;
	logic [ptavg_pkg::STAT_W-1:0] res_status_q;

	logic [ptavg_pkg::TIME_W:0]  diff_w;
	logic [ptavg_pkg::TIME_W:0]  diff_mag_w;
	logic [STEP_W-1:0]           n_w;
	logic [DEG_W-1:0]            deg_w;
	logic [DEN_W:0]              rtry_w;
	logic                        dge_w;
	logic [DEN_W-1:0]            rem_nx_w;
	logic [DIV_W-1:0]            num_nx_w;
	logic                        dlast_w;
	logic [DEG_W-1:0]            coef_idx_w;
	logic [COEF_W-1:0]           coef_rd_w;
	logic [ACC_W-1:0]            coef_scl_w;
	logic [ACC_W-1:0]            acc_mag_w;
	logic [ptavg_pkg::TIME_W-1:0] x_mag_w;
	logic [31:0]                 mul_a_w;
	logic [63:0]                 prod_w;
	logic [MAG_W-1:0]            mag_w;
	logic [ACC_W:0]              scl_w;
	logic [ACC_W:0]              addc_w;
	logic [SUM_W-1:0]            addend_w;
	logic signed [SUM_W-1:0]     sum_w;
	logic signed [SUM_W-1:0]     sum_c_w;
	logic                        sum_ov_w;
	logic [SUM_W-1:0]            sum_mag_w;
	logic [ACC_W:0]              mean_w;
	logic [ptavg_pkg::TIME_W:0]  x_nx_w;
	logic                        res_load_w;

	assign cfg.ready = 1'b1;
	assign job.ready = (state_q == ptavg_pkg::S_IDLE);
	assign res.valid = res_valid_q;
	assign res.avg_velocity = res_avg_q;
	assign res.status = res_status_q;

	// job set-up
	assign diff_w = {job.t_end[ptavg_pkg::TIME_W-1], job.t_end}
		- {job.t_start[ptavg_pkg::TIME_W-1], job.t_start};
	assign diff_mag_w = diff_w[ptavg_pkg::TIME_W] ? (~diff_w + 1'b1) : diff_w;
	assign n_w = (job.step_count > N_MAX) ? N_MAX : job.step_count;
	assign deg_w = (32'(poly_deg_q) > DEG_LIM) ? DEG_W'(DEG_LIM) : poly_deg_q;

	// shared radix-2 restoring divider
	assign rtry_w   = {rem_q, num_q[DIV_W-1]};
	assign dge_w    = rtry_w >= {1'b0, den_q};
	assign rem_nx_w = dge_w ? DEN_W'(rtry_w - {1'b0, den_q}) : rtry_w[DEN_W-1:0];
	assign num_nx_w = {num_q[DIV_W-2:0], dge_w};
	assign dlast_w  = (dcnt_q == '1);

	// coefficient read, one port
	assign coef_idx_w = (state_q == ptavg_pkg::S_POINT) ? deg_q : k_q - 1'b1;
	assign coef_rd_w = (32'(coef_idx_w) < ptavg_pkg::NUM_COEF) ? coef_q[coef_idx_w] : '0;
	assign coef_scl_w = {{(ACC_W-COEF_W){coef_rd_w[COEF_W-1]}}, coef_rd_w} << FRAC_BITS;

	// shared multiplier: low then high partial product of |acc| * |x|
	assign acc_mag_w = acc_q[ACC_W-1] ? (~acc_q + 1'b1) : acc_q;
	assign x_mag_w = x_q[ptavg_pkg::TIME_W-1] ? (~x_q + 1'b1) : x_q;
	assign mul_a_w = (state_q == ptavg_pkg::S_MLO) ? acc_mag_w[31:0]
		: {{(64-ACC_W){1'b0}}, acc_mag_w[ACC_W-1:32]};
	assign prod_w = 64'(mul_a_w) * 64'(x_mag_w);

	assign mag_w = (MAG_W'(phi_q) << (32 - FRAC_BITS)) + MAG_W'(plo_q >> FRAC_BITS);
	assign scl_w = sat48(WIDE_W'(mag_w), acc_q[ACC_W-1] ^ x_q[ptavg_pkg::TIME_W-1]);

	assign addc_w = {acc_q[ACC_W-1], acc_q} + {coef_scl_w[ACC_W-1], coef_scl_w};

	// end points weigh 1, inner points 2
	assign addend_w = ((i_q != '0) && (i_q != n_q))
		? {{(SUM_W-ACC_W-1){acc_q[ACC_W-1]}}, acc_q, 1'b0}
		: {{(SUM_W-ACC_W){acc_q[ACC_W-1]}}, acc_q};
	assign sum_w = sum_q + $signed(addend_w);
	always_comb begin
		sum_ov_w = 1'b0;
		sum_c_w = sum_w;
		if (sum_w > ptavg_pkg::SUM_LIM) begin
			sum_ov_w = 1'b1;
			sum_c_w = ptavg_pkg::SUM_LIM;
		end else if (sum_w < ptavg_pkg::SUM_MIN) begin
			sum_ov_w = 1'b1;
			sum_c_w = ptavg_pkg::SUM_MIN;
		end
	end
	assign sum_mag_w = sum_c_w[SUM_W-1] ? (~sum_c_w + 1'b1) : sum_c_w;

	assign mean_w = sat48(WIDE_W'(num_nx_w), dneg_q);
	assign x_nx_w = {x_q[ptavg_pkg::TIME_W-1], x_q} + h_q;
	assign res_load_w = (state_q == ptavg_pkg::S_DONE) && (!res_valid_q || res.ready);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_deg_q <= '0;
			for (int c = 0; c < ptavg_pkg::NUM_COEF; c++)
				coef_q[c] <= '0;
		end else if (cfg.valid) begin
			if (cfg.addr == ptavg_pkg::REG_DEGREE) begin
				poly_deg_q <= cfg.data[DEG_W-1:0];
			end else if (cfg.addr >= ptavg_pkg::REG_COEF_FIRST
					&& cfg.addr <= ptavg_pkg::REG_COEF_LAST) begin
				coef_q[cfg.addr - ptavg_pkg::REG_COEF_FIRST] <= cfg.data;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load_w) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load_w) begin
			res_avg_q <= fin_avg_q;
			res_status_q <= fin_status_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptavg_pkg::S_IDLE;
		end else begin
			unique case (state_q)
				ptavg_pkg::S_IDLE: begin
					if (job.valid) begin
						if (diff_w == '0 || n_w == '0)
							state_q <= ptavg_pkg::S_DONE;
						else
							state_q <= ptavg_pkg::S_DIVH;
					end
				end
				ptavg_pkg::S_DIVH: begin
					if (dlast_w)
						state_q <= ptavg_pkg::S_POINT;
				end
				ptavg_pkg::S_POINT: begin
					if (deg_q == '0)
						state_q <= ptavg_pkg::S_SUM;
					else
						state_q <= ptavg_pkg::S_MLO;
				end
				ptavg_pkg::S_MLO:   state_q <= ptavg_pkg::S_MHI;
				ptavg_pkg::S_MHI:   state_q <= ptavg_pkg::S_SCALE;
				ptavg_pkg::S_SCALE: state_q <= ptavg_pkg::S_ADDC;
				ptavg_pkg::S_ADDC: begin
					if (k_q == DEG_W'(1))
						state_q <= ptavg_pkg::S_SUM;
					else
						state_q <= ptavg_pkg::S_MLO;
				end
				ptavg_pkg::S_SUM: begin
					if (i_q == n_q)
						state_q <= ptavg_pkg::S_DIVM;
					else
						state_q <= ptavg_pkg::S_POINT;
				end
				ptavg_pkg::S_DIVM: begin
					if (dlast_w)
						state_q <= ptavg_pkg::S_DONE;
				end
				ptavg_pkg::S_DONE: begin
					if (res_load_w)
						state_q <= ptavg_pkg::S_IDLE;
				end
				default: state_q <= ptavg_pkg::S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ptavg_pkg::S_IDLE: begin
				x_q <= job.t_start;
				n_q <= n_w;
				deg_q <= deg_w;
				i_q <= '0;
				sum_q <= '0;
				ov_q <= 1'b0;
				num_q <= DIV_W'(diff_mag_w);
				den_q <= {1'b0, n_w};
				rem_q <= '0;
				dcnt_q <= '0;
				dneg_q <= diff_w[ptavg_pkg::TIME_W];
				fin_avg_q <= '0;
				if (diff_w == '0)
					fin_status_q <= ptavg_pkg::ST_ZERO_LEN;
				else
					fin_status_q <= ptavg_pkg::ST_ZERO_STEPS;
			end
			ptavg_pkg::S_DIVH: begin
				num_q <= num_nx_w;
				rem_q <= rem_nx_w;
				dcnt_q <= dcnt_q + 1'b1;
				if (dlast_w)
					h_q <= dneg_q ? (~num_nx_w[ptavg_pkg::TIME_W:0] + 1'b1)
						: num_nx_w[ptavg_pkg::TIME_W:0];
			end
			ptavg_pkg::S_POINT: begin
				acc_q <= coef_scl_w;
				k_q <= deg_q;
			end
			ptavg_pkg::S_MLO: plo_q <= prod_w;
			ptavg_pkg::S_MHI: phi_q <= prod_w[ACC_W-1:0];
			ptavg_pkg::S_SCALE: begin
				acc_q <= scl_w[ACC_W-1:0];
				if (scl_w[ACC_W])
					ov_q <= 1'b1;
			end
			ptavg_pkg::S_ADDC: begin
				k_q <= k_q - 1'b1;
				if (addc_w[ACC_W] != addc_w[ACC_W-1]) begin
					ov_q <= 1'b1;
					acc_q <= addc_w[ACC_W] ? ptavg_pkg::OUT_MIN : ptavg_pkg::OUT_MAX;
				end else begin
					acc_q <= addc_w[ACC_W-1:0];
				end
			end
			ptavg_pkg::S_SUM: begin
				sum_q <= sum_c_w;
				if (sum_ov_w)
					ov_q <= 1'b1;
				i_q <= i_q + 1'b1;
				x_q <= x_nx_w[ptavg_pkg::TIME_W-1:0];
				// last point: start the mean division
				num_q <= sum_mag_w;
				den_q <= {n_q, 1'b0};
				rem_q <= '0;
				dcnt_q <= '0;
				dneg_q <= sum_c_w[SUM_W-1];
			end
			ptavg_pkg::S_DIVM: begin
				num_q <= num_nx_w;
				rem_q <= rem_nx_w;
				dcnt_q <= dcnt_q + 1'b1;
				if (dlast_w) begin
					fin_avg_q <= mean_w[ACC_W-1:0];
					fin_status_q <= (ov_q || mean_w[ACC_W])
						? ptavg_pkg::ST_SAT : ptavg_pkg::ST_OK;
				end
			end
			ptavg_pkg::S_DONE: begin
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- hdl/ptavg_checker.sv -----
`default_nettype none
`include "polynomial_trapezoid_average_defines.svh"

module ptavg_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           job_valid,
	input wire logic                           job_ready,
	input wire logic                           res_valid,
	input wire logic                           res_ready,
	input wire logic [ptavg_pkg::ACC_W-1:0]    res_avg,
	input wire logic [ptavg_pkg::STAT_W-1:0]   res_status
);

	// a taken job makes the sequencer busy in the following cycle
	`PTAVG_ASSERT_NEXT(a_busy_after_job, job_valid && job_ready, !job_ready, "ready after job transaction")

	// a fresh result only appears as the sequencer returns to idle
	`PTAVG_ASSERT_SAME(a_result_at_idle, $rose(res_valid), job_ready, "result without idle sequencer")

	`PTAVG_ASSERT_SAME(a_error_zero, res_valid && (res_status == ptavg_pkg::ST_ZERO_LEN || res_status == ptavg_pkg::ST_ZERO_STEPS), res_avg == '0, "error result with non-zero value")

	`PTAVG_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_avg) && $stable(res_status), "stalled result changed")

endmodule

bind polynomial_trapezoid_average ptavg_checker u_ptavg_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.job_valid  (job.valid),
	.job_ready  (job.ready),
	.res_valid  (res.valid),
	.res_ready  (res.ready),
	.res_avg    (res.avg_velocity),
	.res_status (res.status)
);

`default_nettype wire
